[rtl/slt_pkg.sv]
// Shared types, constants and helper functions of the small-language tokenizer.
package slt_pkg;

   // Counter widths of line, column, length and byte offset
   localparam int COUNT_WIDTH  = 16;
   localparam int OFFSET_WIDTH = 24;

   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [OFFSET_WIDTH-1:0] offset_type;

   // Result queue sizing; the input side holds off while more than
   // FIFO_DEPTH - FIFO_RESERVE entries are queued
   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_RESERVE = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

   typedef logic [FIFO_PTR_W-1:0] fifo_ptr_type;
   typedef logic [FIFO_CNT_W-1:0] fifo_cnt_type;

   // Scanner modes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_ASSIGN,
      MODE_END
   } mode_type;

   // Token kinds
   typedef enum logic [4:0] {
      KIND_EOF,
      KIND_INT,
      KIND_IF,
      KIND_PRINT,
      KIND_IDENT,
      KIND_NUMBER,
      KIND_PLUS,
      KIND_MINUS,
      KIND_STAR,
      KIND_SLASH,
      KIND_LPAREN,
      KIND_RPAREN,
      KIND_SEMI,
      KIND_ASSIGN,
      KIND_EQEQ,
      KIND_LESS,
      KIND_GREATER,
      KIND_ILLEGAL
   } kind_type;

   // Keyword mask bits
   localparam int KW_INT   = 0;
   localparam int KW_IF    = 1;
   localparam int KW_PRINT = 2;

   // Character codes
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LESS    = 8'h3C;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5A;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_F       = 8'h66;
   localparam logic [7:0] CH_I       = 8'h69;
   localparam logic [7:0] CH_N       = 8'h6E;
   localparam logic [7:0] CH_P       = 8'h70;
   localparam logic [7:0] CH_R       = 8'h72;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_LO_Z    = 8'h7A;

   // One result beat
   typedef struct packed {
      kind_type    kind;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [23:0] start_offset;
      logic [15:0] token_length;
      logic        last;
   } token_type;

   // Up to two tokens produced by one byte; v1 only with v0
   typedef struct packed {
      logic      v0;
      logic      v1;
      token_type t0;
      token_type t1;
   } push_type;

   // Queue status toward the top level
   typedef struct packed {
      fifo_cnt_type count;
      logic         almost_full;
   } fifo_status_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic count_type sat_count(count_type v);
      return (v == '1) ? v : v + count_type'(1);
   endfunction

   function automatic offset_type sat_offset(offset_type v);
      return (v == '1) ? v : v + offset_type'(1);
   endfunction

   // Keywords still matching when byte c sits at position pos
   function automatic logic [2:0] kw_match(count_type pos, logic [7:0] c);
      logic [2:0] m;
      m = '0;
      unique case (pos)
         count_type'(0): begin
            m[KW_INT]   = (c == CH_I);
            m[KW_IF]    = (c == CH_I);
            m[KW_PRINT] = (c == CH_P);
         end
         count_type'(1): begin
            m[KW_INT]   = (c == CH_N);
            m[KW_IF]    = (c == CH_F);
            m[KW_PRINT] = (c == CH_R);
         end
         count_type'(2): begin
            m[KW_INT]   = (c == CH_T);
            m[KW_PRINT] = (c == CH_I);
         end
         count_type'(3): m[KW_PRINT] = (c == CH_N);
         count_type'(4): m[KW_PRINT] = (c == CH_T);
         default:        m = '0;
      endcase
      return m;
   endfunction

   function automatic kind_type ident_kind(logic [2:0] mask, count_type len);
      kind_type k;
      priority if (mask[KW_INT] && (len == count_type'(3)))   k = KIND_INT;
      else if (mask[KW_IF] && (len == count_type'(2)))        k = KIND_IF;
      else if (mask[KW_PRINT] && (len == count_type'(5)))     k = KIND_PRINT;
      else                                                    k = KIND_IDENT;
      return k;
   endfunction

   function automatic kind_type punct_kind(logic [7:0] c);
      kind_type k;
      unique case (c)
         CH_PLUS:    k = KIND_PLUS;
         CH_MINUS:   k = KIND_MINUS;
         CH_STAR:    k = KIND_STAR;
         CH_SLASH:   k = KIND_SLASH;
         CH_LPAREN:  k = KIND_LPAREN;
         CH_RPAREN:  k = KIND_RPAREN;
         CH_SEMI:    k = KIND_SEMI;
         CH_LESS:    k = KIND_LESS;
         CH_GREATER: k = KIND_GREATER;
         default:    k = KIND_ILLEGAL;
      endcase
      return k;
   endfunction

   // Build a result beat; fields wrap to their port widths
   function automatic token_type make_token(kind_type kind, count_type line,
                                            count_type col, offset_type off,
                                            count_type len);
      token_type t;
      t.kind         = kind;
      t.start_line   = 16'(line);
      t.start_column = 16'(col);
      t.start_offset = 24'(off);
      t.token_length = 16'(len);
      t.last         = 1'b0;
      return t;
   endfunction

endpackage

[rtl/slt_scanner.sv]
// Input byte register, scanner state and combinational token recognition.
module slt_scanner
   import slt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_accept,
   input  logic [7:0] byte_ch,
   output push_type   push
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;

   mode_type   mode_ff, mode_in;
   count_type  line_ff, line_in;
   count_type  col_ff, col_in;
   offset_type off_ff, off_in;
   offset_type tok_off_ff, tok_off_in;
   count_type  tok_col_ff, tok_col_in;
   count_type  tok_len_ff, tok_len_in;
   logic [2:0] mask_ff, mask_in;

   logic       va, vb, go_scan;
   logic       do_fresh, do_extend, do_adv, do_assign;
   token_type  tok_a, tok_b;

   // Input register
   assign in_valid_in = byte_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_accept) begin
         in_ch_ff <= byte_ch;
      end
   end

   // Step: close a pending token, then scan the byte on its own
   always_comb begin
      mode_in    = mode_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      off_in     = off_ff;
      tok_off_in = tok_off_ff;
      tok_col_in = tok_col_ff;
      tok_len_in = tok_len_ff;
      mask_in    = mask_ff;
      va         = 1'b0;
      vb         = 1'b0;
      go_scan    = 1'b0;
      do_fresh   = 1'b0;
      do_extend  = 1'b0;
      do_adv     = 1'b0;
      do_assign  = 1'b0;
      tok_a      = make_token(KIND_EOF, line_ff, col_ff, off_ff, '0);
      tok_b      = make_token(KIND_EOF, line_ff, col_ff, off_ff, '0);

      if (in_valid_ff) begin
         go_scan = 1'b1;
         unique case (mode_ff)
            MODE_END: begin
               va      = 1'b1;
               go_scan = 1'b0;
            end
            MODE_IDENT: begin
               if ((in_ch_ff != CH_NUL) &&
                   (is_alpha(in_ch_ff) || is_digit(in_ch_ff) || (in_ch_ff == CH_UNDER))) begin
                  do_extend = 1'b1;
                  go_scan   = 1'b0;
               end else begin
                  va      = 1'b1;
                  tok_a   = make_token(ident_kind(mask_ff, tok_len_ff), line_ff,
                                       tok_col_ff, tok_off_ff, tok_len_ff);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(in_ch_ff)) begin
                  do_extend = 1'b1;
                  go_scan   = 1'b0;
               end else begin
                  va      = 1'b1;
                  tok_a   = make_token(KIND_NUMBER, line_ff, tok_col_ff, tok_off_ff,
                                       tok_len_ff);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_ASSIGN: begin
               mode_in = MODE_IDLE;
               va      = 1'b1;
               if (in_ch_ff == CH_EQUAL) begin
                  tok_a   = make_token(KIND_EQEQ, line_ff, tok_col_ff, tok_off_ff,
                                       count_type'(2));
                  do_adv  = 1'b1;
                  go_scan = 1'b0;
               end else begin
                  tok_a = make_token(KIND_ASSIGN, line_ff, tok_col_ff, tok_off_ff,
                                     count_type'(1));
               end
            end
            default: mode_in = MODE_IDLE;
         endcase

         if (go_scan) begin
            priority if (in_ch_ff == CH_NUL) begin
               vb      = 1'b1;
               mode_in = MODE_END;
            end else if (is_space(in_ch_ff)) begin
               do_adv = 1'b1;
            end else if (is_alpha(in_ch_ff) || (in_ch_ff == CH_UNDER)) begin
               do_fresh  = 1'b1;
               do_extend = 1'b1;
               mode_in   = MODE_IDENT;
            end else if (is_digit(in_ch_ff)) begin
               do_fresh  = 1'b1;
               do_extend = 1'b1;
               mode_in   = MODE_NUMBER;
            end else if (in_ch_ff == CH_EQUAL) begin
               do_fresh  = 1'b1;
               do_assign = 1'b1;
               do_adv    = 1'b1;
               mode_in   = MODE_ASSIGN;
            end else begin
               vb     = 1'b1;
               tok_b  = make_token(punct_kind(in_ch_ff), line_ff, col_ff, off_ff,
                                   count_type'(1));
               do_adv = 1'b1;
            end
         end
      end

      // Token start bookkeeping
      if (do_fresh) begin
         tok_off_in = off_ff;
         tok_col_in = col_ff;
         tok_len_in = '0;
         mask_in    = '1;
      end
      if (do_extend) begin
         mask_in    = mask_in & kw_match(tok_len_in, in_ch_ff);
         tok_len_in = sat_count(tok_len_in);
      end
      if (do_assign) begin
         tok_len_in = count_type'(1);
      end

      // Position tracking
      if (do_extend || do_adv) begin
         if (in_ch_ff == CH_NL) begin
            line_in = sat_count(line_ff);
            col_in  = count_type'(1);
         end else begin
            col_in = sat_count(col_ff);
         end
         off_in = sat_offset(off_ff);
      end

      // Mark the final beat of this byte
      if (vb) begin
         tok_b.last = 1'b1;
      end else if (va) begin
         tok_a.last = 1'b1;
      end

      push.v0 = va | vb;
      push.v1 = va & vb;
      push.t0 = va ? tok_a : tok_b;
      push.t1 = tok_b;
   end

   // Scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         line_ff    <= count_type'(1);
         col_ff     <= count_type'(1);
         off_ff     <= '0;
         tok_off_ff <= '0;
         tok_col_ff <= count_type'(1);
         tok_len_ff <= '0;
         mask_ff    <= '1;
      end else begin
         mode_ff    <= mode_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         off_ff     <= off_in;
         tok_off_ff <= tok_off_in;
         tok_col_ff <= tok_col_in;
         tok_len_ff <= tok_len_in;
         mask_ff    <= mask_in;
      end
   end

endmodule

[rtl/slt_fifo.sv]
// Result queue taking up to two tokens per cycle and giving one per cycle while head_stall is low.
module slt_fifo
   import slt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   input  logic            head_stall,
   output logic            head_valid,
   output token_type       head,
   output fifo_status_type status
);

   token_type    mem [FIFO_DEPTH];
   fifo_ptr_type wr_ptr_ff, wr_ptr_in;
   fifo_ptr_type rd_ptr_ff, rd_ptr_in;
   fifo_cnt_type count_ff, count_in;
   fifo_cnt_type n_push;
   logic         pop;

   // Pointer and fill arithmetic
   always_comb begin
      n_push    = fifo_cnt_type'(push.v0) + fifo_cnt_type'(push.v1);
      pop       = head_valid && !head_stall;
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + n_push - fifo_cnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.v0) begin
         mem[wr_ptr_ff] <= push.t0;
      end
      if (push.v1) begin
         mem[wr_ptr_ff + fifo_ptr_type'(1)] <= push.t1;
      end
   end

   // Head beat and status
   assign head_valid         = (count_ff != '0);
   assign head               = mem[rd_ptr_ff];
   assign status.count       = count_ff;
   assign status.almost_full = (count_ff > fifo_cnt_type'(FIFO_DEPTH - FIFO_RESERVE));

endmodule

[rtl/small_language_tokenizer_top.sv]
// Top level of the small-language tokenizer: scanner plus result queue.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_ch (8 bit source byte)
//   rsp     | out       | rsp_valid/rsp_stall | kind, start line/column/offset, length, last
//
// One byte is taken per cycle while req_stall is low; it is held in the scanner's input register
// and its tokens are then written to the queue, where rsp_valid rises.
// A byte gives zero, one or two beats; the 8-entry queue drains one beat per cycle
// while rsp_stall is low. req_stall is high while more than four beats are queued.
// Synchronous reset returns line and column to 1 and offset to 0 and empties the queue.
module small_language_tokenizer_top
   import slt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_kind,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic [23:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last
);

   push_type        push;
   token_type       head;
   fifo_status_type status;
   logic            byte_accept;

   // Input beat accepted while the queue has room for a byte in flight
   assign req_stall   = status.almost_full;
   assign byte_accept = req_valid && !req_stall;

   slt_scanner u_scanner (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .byte_ch     (req_ch),
      .push        (push)
   );

   slt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .head_stall (rsp_stall),
      .head_valid (rsp_valid),
      .head       (head),
      .status     (status)
   );

   // Result fields
   assign rsp_kind         = head.kind;
   assign rsp_start_line   = head.start_line;
   assign rsp_start_column = head.start_column;
   assign rsp_start_offset = head.start_offset;
   assign rsp_token_length = head.token_length;
   assign rsp_last         = head.last;

   // Checks
   a_push_pack: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> push.v0)
      else $error("second token pushed without a first");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> (!push.t0.last && push.t1.last))
      else $error("last flag misplaced on a token pair");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (push.v0 && !push.v1) |-> push.t0.last)
      else $error("single token missing last flag");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.almost_full |-> !byte_accept ##0 (status.count <= fifo_cnt_type'(FIFO_DEPTH)))
      else $error("result queue overflow");

endmodule
